### src/ctlm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctlm_pkg
// Shared types and constants of the CD track table and LBA mapper.
// ----------------------------------------------------------------------------
package ctlm_pkg;

  localparam int MAX_TRACKS  = 128;
  localparam int FRAME_BYTES = 2448;
  localparam int IDX_W       = $clog2(MAX_TRACKS);
  localparam int CNT_W       = $clog2(MAX_TRACKS + 1);
  localparam int ENTRY_W     = 48 + 32 + 34;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  localparam logic [2:0] ST_DATA  = 3'd0;
  localparam logic [2:0] ST_AUDIO = 3'd1;
  localparam logic [2:0] ST_GAP   = 3'd2;
  localparam logic [2:0] ST_FAR   = 3'd3;
  localparam logic [2:0] ST_WROTE = 3'd4;

  localparam logic [1:0] REG_SPH   = 2'd0;
  localparam logic [1:0] REG_DLEN  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] lba;
    logic [6:0]  entry_index;
    logic [6:0]  trk_num;
    logic [23:0] first_lba;
    logic [23:0] img_frame;
    logic [15:0] pre_len;
    logic [23:0] body_len;
    logic [15:0] post_len;
    logic        audio_track;
    logic [1:0]  subchannel_kind;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  found_track;
    logic [23:0] hunk_num;
    logic [19:0] hunk_byte_offset;
    logic        swap_bytes;
    logic [1:0]  subchannel_source;
    logic [23:0] track_start;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;      // capture input word
    logic             mem_wr;    // write table entry
    logic             mem_rd;    // issue table read at rd_addr
    logic [IDX_W-1:0] rd_addr;
    logic             div_start; // start hunk division
    logic             div_step;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit_gap;
    logic hit_data;
  } dp_stat_t;

endpackage
`default_nettype wire

### src/cd_track_lba_mapper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cd_track_lba_mapper
// CD track table with LBA lookup to hunk index and byte offset.
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// in      | start / busy         | in_word (in_word_t)
// out     | out_strobe (1 cycle) | out_word (out_word_t)
// cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Writes, start queries answered from registers and lookups on an empty table
// put the result word out straight from the dispatch state; a start query that
// reads the table passes a read state and an output state. A lookup scans one
// entry per cycle and a data hit adds 25 divider steps and a capture step.
// busy is low again in the result cycle.
// Reset clears control state and registers, not the table. No receiver stall.
// ----------------------------------------------------------------------------
module cd_track_lba_mapper (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ctlm_pkg::in_word_t in_word,
  output logic                    out_strobe,
  output ctlm_pkg::out_word_t     out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);
  import ctlm_pkg::*;

  logic [8:0]  sph_r;
  logic [23:0] dlen_r;
  logic [7:0]  cnt_r;

  ctl_cmd_t    cmd;
  dp_stat_t    stat;
  logic [23:0] ent_start, quot, req_lba;
  logic [6:0]  ent_track, req_track;
  logic [19:0] byte_off;
  logic        ent_audio;
  logic [1:0]  ent_sub, req_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sph_r  <= 9'd8;
      dlen_r <= '0;
      cnt_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPH:   sph_r  <= cfg_data[8:0];
        REG_DLEN:  dlen_r <= cfg_data;
        REG_COUNT: cnt_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ctlm_datapath u_dp (
    .clk(clk), .in_word(in_word), .cmd(cmd), .sph(sph_r), .stat(stat),
    .ent_start(ent_start), .ent_track(ent_track), .quot(quot), .byte_off(byte_off),
    .ent_audio(ent_audio), .ent_sub(ent_sub), .req_track(req_track),
    .req_lba(req_lba), .req_cmd(req_cmd)
  );

  ctlm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start),
    .tracks(cnt_r), .disc_len(dlen_r), .stat(stat), .ent_start(ent_start),
    .ent_track(ent_track), .quot(quot), .byte_off(byte_off), .ent_audio(ent_audio),
    .ent_sub(ent_sub), .req_track(req_track), .req_lba(req_lba), .req_cmd(req_cmd),
    .cmd(cmd), .busy(busy), .out_strobe(out_strobe), .out_word(out_word)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$past(out_strobe)) else $error("back-to-back result");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && cmd.mem_wr) |-> 1'b0) else $error("write overlaps result");
endmodule
`default_nettype wire

### src/ctlm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctlm_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module ctlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

### src/ctlm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctlm_datapath
// Track table, range compare and restoring hunk divider.
// ----------------------------------------------------------------------------
module ctlm_datapath (
  input  wire logic               clk,
  input  wire ctlm_pkg::in_word_t in_word,
  input  wire ctlm_pkg::ctl_cmd_t cmd,
  input  wire logic [8:0]         sph,
  output ctlm_pkg::dp_stat_t      stat,
  output logic [23:0]             ent_start,
  output logic [6:0]              ent_track,
  output logic [23:0]             quot,
  output logic [19:0]             byte_off,
  output logic                    ent_audio,
  output logic [1:0]              ent_sub,
  output logic [6:0]              req_track,
  output logic [23:0]             req_lba,
  output logic [1:0]              req_cmd
);
  import ctlm_pkg::*;

  in_word_t           w_r;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] wr_data;

  logic [23:0] e_start, e_data, e_ff;
  logic [15:0] e_pre, e_post;
  logic [24:0] data_end;
  logic [25:0] post_end;
  logic [23:0] pre_start;
  logic [24:0] frame;
  logic [8:0]  sph_eff;

  // divider state: 25-bit dividend shifted through remainder
  logic [24:0] dvd_r, dvd_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [9:0]  trial;
  logic [23:0] frame_lo;

  assign wr_data = {w_r.first_lba, w_r.body_len, w_r.pre_len, w_r.post_len,
                    w_r.img_frame, w_r.audio_track, w_r.subchannel_kind, w_r.trk_num};

  ctlm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TRACKS)) u_table (
    .clk     (clk),
    .wr_en   (cmd.mem_wr),
    .wr_addr (w_r.entry_index[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (cmd.mem_rd),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_data)
  );

  assign {e_start, e_data, e_pre, e_post, e_ff, ent_audio, ent_sub, ent_track} = rd_data;

  assign pre_start = (e_start > {8'd0, e_pre}) ? e_start - {8'd0, e_pre} : 24'd0;
  assign data_end  = {1'b0, e_start} + {1'b0, e_data};
  assign post_end  = {1'b0, data_end} + {10'd0, e_post};
  assign ent_start = e_start;

  always_comb begin
    stat.hit_gap  = (w_r.lba >= pre_start && w_r.lba < e_start) ||
                    ({1'b0, w_r.lba} >= data_end && {2'b0, w_r.lba} < post_end);
    stat.hit_data = (w_r.lba >= e_start) && ({1'b0, w_r.lba} < data_end);
  end

  assign frame_lo = w_r.lba - e_start;
  assign frame    = {1'b0, e_ff} + {1'b0, frame_lo};
  assign sph_eff  = (sph == 9'd0) ? 9'd1 : ((sph > 9'd256) ? 9'd256 : sph);
  assign trial    = {rem_r, dvd_r[24]};

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    if (cmd.div_start) begin
      dvd_nxt = frame;
      rem_nxt = 9'd0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, sph_eff}) begin
        rem_nxt = 9'(trial - {1'b0, sph_eff});
        dvd_nxt = {dvd_r[23:0], 1'b1};
      end else begin
        rem_nxt = trial[8:0];
        dvd_nxt = {dvd_r[23:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r <= in_word;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign quot     = dvd_r[23:0];
  assign byte_off = 20'({11'd0, rem_r} * 20'(FRAME_BYTES));
  assign req_track = w_r.trk_num;
  assign req_lba   = w_r.lba;
  assign req_cmd   = w_r.command;
endmodule
`default_nettype wire

### src/ctlm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctlm_ctrl
// Command sequencer: table scan, divider steps and result formatting.
// ----------------------------------------------------------------------------
module ctlm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [7:0]         tracks,
  input  wire logic [23:0]        disc_len,
  input  wire ctlm_pkg::dp_stat_t stat,
  input  wire logic [23:0]        ent_start,
  input  wire logic [6:0]         ent_track,
  input  wire logic [23:0]        quot,
  input  wire logic [19:0]        byte_off,
  input  wire logic               ent_audio,
  input  wire logic [1:0]         ent_sub,
  input  wire logic [6:0]         req_track,
  input  wire logic [23:0]        req_lba,
  input  wire logic [1:0]         req_cmd,
  output ctlm_pkg::ctl_cmd_t      cmd,
  output logic                    busy,
  output logic                    out_strobe,
  output ctlm_pkg::out_word_t     out_word
);
  import ctlm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_SCAN, S_DIV, S_START_RD, S_START_OUT}
    state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;     // entry whose read data is valid now
  logic [4:0]          step_r, step_nxt;
  logic [CNT_W-1:0]    count;
  logic [6:0]          trk_r, trk_nxt;
  logic                audio_r, audio_nxt;
  logic [1:0]          sub_r, sub_nxt;
  logic                strobe_r, strobe_nxt;
  out_word_t           out_r, out_nxt;

  assign count = (tracks > 8'(MAX_TRACKS)) ? CNT_W'(MAX_TRACKS) : CNT_W'(tracks);
  assign busy  = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_word   = out_r;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && start;
    cmd.rd_addr   = idx_r[IDX_W-1:0];
    case (state_r)
      S_DISPATCH: begin
        cmd.mem_wr  = (req_cmd == CMD_WRITE);
        cmd.mem_rd  = (req_cmd == CMD_LOOKUP);
        cmd.rd_addr = '0;
      end
      S_SCAN: begin
        cmd.mem_rd    = 1'b1;
        cmd.rd_addr   = IDX_W'(idx_r + 1'b1);
        cmd.div_start = stat.hit_data;
      end
      // last cycle only captures the settled quotient
      S_DIV:      cmd.div_step = (step_r != 5'd25);
      S_START_RD: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_addr = IDX_W'(req_track - 7'd1);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    step_nxt   = step_r;
    trk_nxt    = trk_r;
    audio_nxt  = audio_r;
    sub_nxt    = sub_r;
    strobe_nxt = 1'b0;
    out_nxt    = out_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        out_nxt    = '0;
        idx_nxt    = '0;
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        case (req_cmd)
          CMD_WRITE: out_nxt.status = ST_WROTE;
          CMD_LOOKUP: begin
            if (count == '0) begin
              out_nxt.status = (req_lba < disc_len) ? ST_GAP : ST_FAR;
            end else begin
              strobe_nxt = 1'b0;
              state_nxt  = S_SCAN;
            end
          end
          CMD_START: begin
            if (req_track == 7'd0) begin
              out_nxt.track_start = disc_len;
            end else if (CNT_W'(req_track) <= count) begin
              strobe_nxt = 1'b0;
              state_nxt  = S_START_RD;
            end else begin
              out_nxt.status = ST_FAR;
            end
          end
          default: out_nxt.status = ST_FAR;
        endcase
      end
      S_SCAN: begin
        if (stat.hit_gap) begin
          out_nxt.status      = ST_GAP;
          out_nxt.found_track = ent_track;
          strobe_nxt          = 1'b1;
          state_nxt           = S_IDLE;
        end else if (stat.hit_data) begin
          trk_nxt   = ent_track;
          audio_nxt = ent_audio;
          sub_nxt   = (ent_sub == 2'd3) ? 2'd0 : ent_sub;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end else if (idx_r + 1'b1 >= count) begin
          out_nxt.status = (req_lba < disc_len) ? ST_GAP : ST_FAR;
          strobe_nxt     = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DIV: begin
        // 25 quotient bits, one per cycle, then capture
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd25) begin
          out_nxt.status            = audio_r ? ST_AUDIO : ST_DATA;
          out_nxt.found_track       = trk_r;
          out_nxt.hunk_num          = quot;
          out_nxt.hunk_byte_offset  = byte_off;
          out_nxt.swap_bytes        = audio_r;
          out_nxt.subchannel_source = sub_r;
          strobe_nxt                = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end
      S_START_RD: state_nxt = S_START_OUT;
      S_START_OUT: begin
        out_nxt.track_start = ent_start;
        strobe_nxt          = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
      idx_r    <= '0;
      step_r   <= '0;
      trk_r    <= '0;
      audio_r  <= 1'b0;
      sub_r    <= '0;
      out_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      idx_r    <= idx_nxt;
      step_r   <= step_nxt;
      trk_r    <= trk_nxt;
      audio_r  <= audio_nxt;
      sub_r    <= sub_nxt;
      out_r    <= out_nxt;
    end
  end
endmodule
`default_nettype wire
